// File: sv/slpk_pkg.sv
// ----------------------------------------------------------------------------
// slpk_pkg
// Shared constants, types and register codes of the stereo peak limiter.
// ----------------------------------------------------------------------------
package slpk_pkg;

  localparam int SAMPLE_WIDTH_DEF   = 24;
  localparam int COEF_FRAC_BITS_DEF = 24;
  localparam int SAMPLE_INT_BITS    = 5;   // Q4.19 plus sign
  localparam int REG_W              = 24;
  localparam int GAIN_FRAC          = 24;
  localparam int GAIN_W             = 25;
  localparam int OUT_W              = 16;
  localparam int SCALE_SHIFT        = 15;  // 32767 = 2^15 - 1
  localparam int QUEUE_DEPTH        = 2;
  localparam int CFG_IDX_W          = 2;

  localparam logic [GAIN_W-1:0] GAIN_ONE        = 25'h100_0000;
  localparam logic [REG_W-1:0]  THRESHOLD_RESET = 24'd14952709;
  localparam logic [REG_W-1:0]  ATTACK_RESET    = 24'd375852;
  localparam logic [REG_W-1:0]  RELEASE_RESET   = 24'd7610;
  localparam logic [OUT_W-1:0]  OUT_MAX         = 16'h7FFF;
  localparam logic [OUT_W-1:0]  OUT_MIN         = 16'h8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_ATTACK    = 2'd1,
    CFG_RELEASE   = 2'd2
  } slpk_cfg_idx_t;

  // classification made at the front, carried with each frame
  typedef struct packed {
    logic limit;
    logic lneg;
    logic rneg;
    logic eob;
  } slpk_flags_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_STEP,
    BK_GAIN,
    BK_MUL_L,
    BK_MUL_R,
    BK_SCALE_R,
    BK_OUT
  } slpk_bk_state_t;

endpackage

// File: sv/stereo_peak_limiter.sv
// ----------------------------------------------------------------------------
// stereo_peak_limiter
// Linked stereo peak limiter with smoothed gain and int16 output.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  input     push / full            left_sample, right_sample, end_of_buffer
//  result    empty / pop            left_out, right_out, applied_gain,
//                                   end_of_buffer_out
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  A frame above threshold runs the radix-2 divider in the back sequencer;
//  a frame at or below threshold skips it and targets unity gain.
//  A two-entry queue lets the front keep accepting while the back works or
//  a result waits. Synchronous reset restores unity gain and the register
//  defaults. cfg_ready is always high.
// ----------------------------------------------------------------------------
module stereo_peak_limiter import slpk_pkg::*; #(
  parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic signed [SAMPLE_WIDTH-1:0] left_sample,
  input  logic signed [SAMPLE_WIDTH-1:0] right_sample,
  input  logic                           end_of_buffer,
  output logic                           empty,
  input  logic                           pop,
  output logic signed [OUT_W-1:0]        left_out,
  output logic signed [OUT_W-1:0]        right_out,
  output logic [GAIN_W-1:0]              applied_gain,
  output logic                           end_of_buffer_out,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [REG_W-1:0]               cfg_data
);

  localparam int EW = 3 * SAMPLE_WIDTH + $bits(slpk_flags_t);

  logic [REG_W-1:0]        threshold_level;
  logic [REG_W-1:0]        attack_step;
  logic [REG_W-1:0]        release_step;

  logic                    q_push;
  logic                    q_pop;
  logic                    q_full;
  logic                    q_empty;
  logic [EW-1:0]           q_rdata;
  slpk_flags_t             fr_flags;
  logic [SAMPLE_WIDTH-1:0] fr_lmag;
  logic [SAMPLE_WIDTH-1:0] fr_rmag;
  logic [SAMPLE_WIDTH-1:0] fr_peak;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_level <= THRESHOLD_RESET;
      attack_step     <= ATTACK_RESET;
      release_step    <= RELEASE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (slpk_cfg_idx_t'(cfg_index))
        CFG_THRESHOLD: threshold_level <= cfg_data;
        CFG_ATTACK:    attack_step     <= cfg_data;
        CFG_RELEASE:   release_step    <= cfg_data;
        default: ;
      endcase
    end
  end

  slpk_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .push            (push),
    .full            (full),
    .left_sample     (left_sample),
    .right_sample    (right_sample),
    .end_of_buffer   (end_of_buffer),
    .threshold_level (threshold_level),
    .q_full          (q_full),
    .q_push          (q_push),
    .flags           (fr_flags),
    .lmag            (fr_lmag),
    .rmag            (fr_rmag),
    .peak            (fr_peak)
  );

  slpk_queue #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .pop   (q_pop),
    .wdata ({fr_flags, fr_peak, fr_rmag, fr_lmag}),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  slpk_back #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .q_empty           (q_empty),
    .q_rdata           (q_rdata),
    .q_pop             (q_pop),
    .threshold_level   (threshold_level),
    .attack_step       (attack_step),
    .release_step      (release_step),
    .pop               (pop),
    .empty             (empty),
    .left_out          (left_out),
    .right_out         (right_out),
    .applied_gain      (applied_gain),
    .end_of_buffer_out (end_of_buffer_out)
  );

`ifndef ASSERT_OFF
  a_gain_bounded: assert property (@(posedge clk) disable iff (rst)
    !empty |-> applied_gain <= GAIN_ONE)
    else $error("applied gain above unity");

  a_zero_gain_silent: assert property (@(posedge clk) disable iff (rst)
    (!empty && applied_gain == '0) |-> (left_out == '0 && right_out == '0))
    else $error("nonzero output at zero gain");

  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> !q_empty)
    else $error("accepted frame missing from queue");
`endif

endmodule

// File: sv/slpk_front.sv
// ----------------------------------------------------------------------------
// slpk_front
// Accepts frames, takes sample magnitudes and the linked peak, and flags
// frames whose peak is above threshold.
// ----------------------------------------------------------------------------
module slpk_front import slpk_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                         push,
  output logic                         full,
  input  logic signed [SAMPLE_WIDTH-1:0] left_sample,
  input  logic signed [SAMPLE_WIDTH-1:0] right_sample,
  input  logic                         end_of_buffer,
  input  logic [REG_W-1:0]             threshold_level,
  input  logic                         q_full,
  output logic                         q_push,
  output slpk_flags_t                  flags,
  output logic [SAMPLE_WIDTH-1:0]      lmag,
  output logic [SAMPLE_WIDTH-1:0]      rmag,
  output logic [SAMPLE_WIDTH-1:0]      peak
);

  localparam int SF    = SAMPLE_WIDTH - SAMPLE_INT_BITS;
  localparam int CMP_W = SAMPLE_WIDTH + GAIN_FRAC;

  logic [SAMPLE_WIDTH-1:0] left_u;
  logic [SAMPLE_WIDTH-1:0] right_u;
  logic [CMP_W-1:0]        pk_scaled;
  logic [CMP_W-1:0]        thr_scaled;

  assign full   = q_full;
  assign q_push = push && !q_full;

  assign left_u  = left_sample;
  assign right_u = right_sample;

  always_comb begin
    flags.lneg = left_u[SAMPLE_WIDTH-1];
    flags.rneg = right_u[SAMPLE_WIDTH-1];
    flags.eob  = end_of_buffer;
    // most negative sample maps to 2^(W-1), still fits unsigned
    lmag = flags.lneg ? (~left_u + 1'b1) : left_u;
    rmag = flags.rneg ? (~right_u + 1'b1) : right_u;
    peak = (lmag > rmag) ? lmag : rmag;
    pk_scaled  = {peak, {GAIN_FRAC{1'b0}}};
    thr_scaled = CMP_W'({threshold_level, {SF{1'b0}}});
    // strict compare against a nonnegative value also rules out a zero peak
    flags.limit = pk_scaled > thr_scaled;
  end

endmodule

// File: sv/slpk_queue.sv
// ----------------------------------------------------------------------------
// slpk_queue
// Small register queue between the front and back parts.
// ----------------------------------------------------------------------------
module slpk_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic             pop,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

// File: sv/slpk_div.sv
// ----------------------------------------------------------------------------
// slpk_div
// Radix-2 restoring divider: threshold * 2^frac / peak, one quotient bit
// per cycle. Quotient is known to fit the gain fraction width.
// ----------------------------------------------------------------------------
module slpk_div import slpk_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [REG_W-1:0]        threshold,
  input  logic [SAMPLE_WIDTH-1:0] divisor,
  output logic                    done,
  output logic [GAIN_FRAC-1:0]    quotient
);

  localparam int SF    = SAMPLE_WIDTH - SAMPLE_INT_BITS;
  localparam int DW    = REG_W + SF;
  localparam int CNT_W = $clog2(GAIN_FRAC + 1);

  logic [DW-1:0]           dvd;
  logic [SAMPLE_WIDTH-1:0] rem;
  logic [SAMPLE_WIDTH-1:0] dsr;
  logic [GAIN_FRAC-1:0]    low;
  logic [CNT_W-1:0]        cnt;
  logic [SAMPLE_WIDTH:0]   trial;
  logic [SAMPLE_WIDTH:0]   trial_sub;
  logic                    fits;

  assign dvd       = {threshold, {SF{1'b0}}};
  assign trial     = {rem, low[GAIN_FRAC-1]};
  assign fits      = trial >= {1'b0, dsr};
  assign trial_sub = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == CNT_W'(1));
      if (start) begin
        cnt <= CNT_W'(GAIN_FRAC);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // upper dividend bits start below the divisor, so the remainder stays narrow
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= SAMPLE_WIDTH'(dvd[DW-1:GAIN_FRAC]);
      low <= dvd[GAIN_FRAC-1:0];
      dsr <= divisor;
    end else if (cnt != '0) begin
      rem      <= fits ? trial_sub[SAMPLE_WIDTH-1:0] : trial[SAMPLE_WIDTH-1:0];
      low      <= {low[GAIN_FRAC-2:0], 1'b0};
      quotient <= {quotient[GAIN_FRAC-2:0], fits};
    end
  end

endmodule

// File: sv/slpk_back.sv
// ----------------------------------------------------------------------------
// slpk_back
// Sequencer that divides for the target gain, smooths the kept gain, scales
// both channels on one shared multiplier and holds the result register.
// ----------------------------------------------------------------------------
module slpk_back import slpk_pkg::*; #(
  parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_empty,
  input  logic [3*SAMPLE_WIDTH+$bits(slpk_flags_t)-1:0] q_rdata,
  output logic                      q_pop,
  input  logic [REG_W-1:0]          threshold_level,
  input  logic [REG_W-1:0]          attack_step,
  input  logic [REG_W-1:0]          release_step,
  input  logic                      pop,
  output logic                      empty,
  output logic signed [OUT_W-1:0]   left_out,
  output logic signed [OUT_W-1:0]   right_out,
  output logic [GAIN_W-1:0]         applied_gain,
  output logic                      end_of_buffer_out
);

  localparam int SF      = SAMPLE_WIDTH - SAMPLE_INT_BITS;
  localparam int MW      = (SAMPLE_WIDTH > GAIN_W) ? SAMPLE_WIDTH : GAIN_W;
  localparam int PW      = MW + GAIN_W;
  localparam int PSTEP_W = GAIN_W + REG_W;
  localparam int STEP_W  = PSTEP_W - COEF_FRAC_BITS;
  localparam int SUM_W   = ((STEP_W > GAIN_W) ? STEP_W : GAIN_W) + 1;
  localparam int MAG_W   = SF + GAIN_W;
  localparam int SCL_W   = MAG_W + SCALE_SHIFT;

  slpk_bk_state_t state, state_next;

  slpk_flags_t             hd_flags;
  logic [SAMPLE_WIDTH-1:0] hd_peak;
  logic [SAMPLE_WIDTH-1:0] hd_rmag;
  logic [SAMPLE_WIDTH-1:0] hd_lmag;

  slpk_flags_t             flags;
  logic [SAMPLE_WIDTH-1:0] lmag;
  logic [SAMPLE_WIDTH-1:0] rmag;
  logic [GAIN_W-1:0]       target;
  logic [GAIN_W-1:0]       gain;
  logic [GAIN_W-1:0]       gain_new;
  logic                    dir_down;
  logic [PW-1:0]           prod;
  logic [OUT_W-1:0]        left_res;
  logic [OUT_W-1:0]        right_res;
  logic                    out_valid;

  logic                    div_start;
  logic                    div_done;
  logic [GAIN_FRAC-1:0]    quotient;

  logic                    down;
  logic [GAIN_W-1:0]       diff;
  logic [REG_W-1:0]        coef;
  logic [MW-1:0]           mul_a;
  logic [GAIN_W-1:0]       mul_b;
  logic [PW-1:0]           mul_p;
  logic [SUM_W-1:0]        step_x;
  logic [SUM_W-1:0]        gain_x;
  logic [SUM_W-1:0]        sum_x;
  logic                    out_free;

  assign {hd_flags, hd_peak, hd_rmag, hd_lmag} = q_rdata;

  slpk_div #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .threshold (threshold_level),
    .divisor   (hd_peak),
    .done      (div_done),
    .quotient  (quotient)
  );

  // sample * gain * 32767 / 2^(frac+24), truncated, saturated to int16
  function automatic logic [OUT_W-1:0] scale_code(input logic [PW-1:0] m, input logic neg);
    logic             sat;
    logic [SCL_W-1:0] big;
    logic [OUT_W-1:0] r;
    logic [OUT_W-1:0] code;
    sat = |m[PW-1:MAG_W];
    big = {m[MAG_W-1:0], {SCALE_SHIFT{1'b0}}} - SCL_W'(m[MAG_W-1:0]);
    r   = big[SCL_W-1:SCL_W-OUT_W];
    if (neg) begin
      code = (sat || r > OUT_MIN) ? OUT_MIN : (~r + 1'b1);
    end else begin
      code = (sat || r > OUT_MAX) ? OUT_MAX : r;
    end
    return code;
  endfunction

  always_comb begin
    down = target < gain;
    diff = down ? (gain - target) : (target - gain);
    coef = down ? attack_step : release_step;
    case (state)
      BK_STEP: begin
        mul_a = MW'(diff);
        mul_b = GAIN_W'(coef);
      end
      BK_MUL_L: begin
        mul_a = MW'(lmag);
        mul_b = gain;
      end
      BK_MUL_R: begin
        mul_a = MW'(rmag);
        mul_b = gain;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = PW'(mul_a) * PW'(mul_b);
  end

  always_comb begin
    step_x = SUM_W'(prod[PSTEP_W-1:COEF_FRAC_BITS]);
    gain_x = SUM_W'(gain);
    sum_x  = gain_x + step_x;
    if (dir_down) begin
      gain_new = (step_x > gain_x) ? '0 : GAIN_W'(gain_x - step_x);
    end else begin
      gain_new = (sum_x > SUM_W'(GAIN_ONE)) ? GAIN_ONE : GAIN_W'(sum_x);
    end
  end

  assign out_free = !out_valid || pop;
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    div_start  = 1'b0;
    case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          div_start  = hd_flags.limit;
          state_next = hd_flags.limit ? BK_DIV : BK_STEP;
        end
      end
      BK_DIV: begin
        if (div_done) begin
          state_next = BK_STEP;
        end
      end
      BK_STEP:    state_next = BK_GAIN;
      BK_GAIN:    state_next = BK_MUL_L;
      BK_MUL_L:   state_next = BK_MUL_R;
      BK_MUL_R:   state_next = BK_SCALE_R;
      BK_SCALE_R: state_next = BK_OUT;
      BK_OUT: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain      <= GAIN_ONE;
      out_valid <= 1'b0;
    end else begin
      if (state == BK_GAIN) begin
        gain <= gain_new;
      end
      if (state == BK_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        if (q_pop) begin
          flags  <= hd_flags;
          lmag   <= hd_lmag;
          rmag   <= hd_rmag;
          target <= GAIN_ONE;
        end
      end
      BK_DIV: begin
        if (div_done) begin
          target <= GAIN_W'(quotient);
        end
      end
      BK_STEP: begin
        dir_down <= down;
        prod     <= mul_p;
      end
      BK_MUL_L: begin
        prod <= mul_p;
      end
      BK_MUL_R: begin
        left_res <= scale_code(prod, flags.lneg);
        prod     <= mul_p;
      end
      BK_SCALE_R: begin
        right_res <= scale_code(prod, flags.rneg);
      end
      BK_OUT: begin
        if (out_free) begin
          left_out          <= left_res;
          right_out         <= right_res;
          applied_gain      <= gain;
          end_of_buffer_out <= flags.eob;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: sim/limiter_check_pkg.sv
// ----------------------------------------------------------------------------
// limiter_check_pkg
// Gain tracker for the stereo peak limiter bench: mirrors the register set
// and the smoothed gain, predicts each frame's output and checks results.
// ----------------------------------------------------------------------------
package limiter_check_pkg;
  import slpk_pkg::*;

  localparam int SAMPLE_W     = SAMPLE_WIDTH_DEF;
  localparam int SAMPLE_FRAC  = SAMPLE_W - SAMPLE_INT_BITS;
  localparam int COEF_FRAC    = COEF_FRAC_BITS_DEF;
  localparam int REPORT_LIMIT = 10;
  localparam bit [63:0] GAIN_MASK  = (64'd1 << GAIN_FRAC) - 64'd1;
  localparam bit [63:0] FULL_SCALE = 64'd32767;
  localparam bit [63:0] NEG_LIMIT  = 64'd32768;
  localparam bit [63:0] WRAP_16    = 64'h1_0000;

  typedef struct packed {
    logic [OUT_W-1:0]  left;
    logic [OUT_W-1:0]  right;
    logic [GAIN_W-1:0] gain;
    logic              eob;
  } frame_result_t;

  class limiter_ledger;
    logic [REG_W-1:0]  thr_level;
    logic [REG_W-1:0]  atk_step;
    logic [REG_W-1:0]  rel_step;
    logic [GAIN_W-1:0] gain;
    logic [GAIN_W-1:0] lowest_gain;
    frame_result_t     expected_frames[$];
    int frames_noted;
    int results_checked;
    int mismatches;
    int reductions;

    function new();
      thr_level   = THRESHOLD_RESET;
      atk_step    = ATTACK_RESET;
      rel_step    = RELEASE_RESET;
      gain        = GAIN_ONE;
      lowest_gain = GAIN_ONE;
    endfunction

    function int pending();
      return expected_frames.size();
    endfunction

    function void write_reg(slpk_cfg_idx_t idx, logic [REG_W-1:0] val);
      case (idx)
        CFG_THRESHOLD: thr_level = val;
        CFG_ATTACK:    atk_step  = val;
        CFG_RELEASE:   rel_step  = val;
        default: ;
      endcase
    endfunction

    function logic [SAMPLE_W-1:0] magnitude(logic signed [SAMPLE_W-1:0] v);
      logic [SAMPLE_W-1:0] u;
      u = v;
      return u[SAMPLE_W-1] ? SAMPLE_W'(~u + 1'b1) : u;
    endfunction

    // truncate toward zero, then clamp to int16
    function logic [OUT_W-1:0] to_int16(logic [SAMPLE_W-1:0] mag, logic neg,
                                        logic [GAIN_W-1:0] g);
      bit [63:0] prod;
      bit [63:0] r;
      prod = 64'(mag) * 64'(g);
      if (prod >= (64'd1 << (SAMPLE_FRAC + GAIN_FRAC + 1)))
        r = 64'hFFFF;
      else
        r = ((prod >> GAIN_FRAC) * FULL_SCALE +
             (((prod & GAIN_MASK) * FULL_SCALE) >> GAIN_FRAC)) >> SAMPLE_FRAC;
      if (neg) begin
        if (r > NEG_LIMIT) r = NEG_LIMIT;
        r = WRAP_16 - r;
      end else if (r > FULL_SCALE) begin
        r = FULL_SCALE;
      end
      return r[OUT_W-1:0];
    endfunction

    function void note_frame(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r,
                             logic eob);
      logic [SAMPLE_W-1:0] lmag;
      logic [SAMPLE_W-1:0] rmag;
      logic [SAMPLE_W-1:0] peak;
      bit [63:0] thr_s;
      bit [63:0] target;
      bit [63:0] g;
      bit [63:0] diff;
      bit [63:0] step;
      frame_result_t want;
      lmag  = magnitude(l);
      rmag  = magnitude(r);
      peak  = (lmag > rmag) ? lmag : rmag;
      thr_s = 64'(thr_level) << SAMPLE_FRAC;
      g     = 64'(gain);
      // strict compare; a zero threshold drives the target to zero
      if ((64'(peak) << GAIN_FRAC) > thr_s && peak != 0)
        target = thr_s / 64'(peak);
      else
        target = 64'(GAIN_ONE);
      if (target < g) begin
        diff = g - target;
        step = (diff * 64'(atk_step)) >> COEF_FRAC;
        g    = (step > g) ? 64'd0 : g - step;
        reductions++;
      end else begin
        diff = target - g;
        step = (diff * 64'(rel_step)) >> COEF_FRAC;
        g    = g + step;
        if (g > 64'(GAIN_ONE)) g = 64'(GAIN_ONE);
      end
      gain = g[GAIN_W-1:0];
      if (gain < lowest_gain) lowest_gain = gain;
      want.left  = to_int16(lmag, l[SAMPLE_W-1], gain);
      want.right = to_int16(rmag, r[SAMPLE_W-1], gain);
      want.gain  = gain;
      want.eob   = eob;
      expected_frames.push_back(want);
      frames_noted++;
    endfunction

    function void check_frame(frame_result_t got);
      frame_result_t want;
      results_checked++;
      if (expected_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("ERROR: result with no frame outstanding: L=%0d R=%0d G=%0d E=%0b",
                   $signed(got.left), $signed(got.right), got.gain, got.eob);
        return;
      end
      want = expected_frames.pop_front();
      if (got.left !== want.left || got.right !== want.right ||
          got.gain !== want.gain || got.eob !== want.eob) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("ERROR: result %0d: expected L=%0d R=%0d G=%0d E=%0b, got L=%0d R=%0d G=%0d E=%0b",
                   results_checked, $signed(want.left), $signed(want.right), want.gain,
                   want.eob, $signed(got.left), $signed(got.right), got.gain, got.eob);
      end
    endfunction
  endclass

endpackage

// File: sim/stereo_peak_limiter_tb.sv
// ----------------------------------------------------------------------------
// stereo_peak_limiter_tb
// Self-checking bench: directed edge frames, then bursts of quiet, loud and
// near-threshold audio under several register settings, with random stalls
// on both queue sides. Every result is checked against the gain tracker.
// ----------------------------------------------------------------------------
module stereo_peak_limiter_tb import slpk_pkg::*, limiter_check_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 40;   // longest frame in the back end is one that runs the divider
  localparam int PHASE_FRAMES = 250;
  localparam int IDLE_PCT     = 12;
  localparam int MAX_POS      = 8388607;
  localparam int FULL_MAG     = 8388608;
  localparam logic [SAMPLE_W-1:0] POS_FULL = 24'h7FFFFF;
  localparam logic [SAMPLE_W-1:0] NEG_FULL = 24'h800000;
  localparam logic [REG_W-1:0]    REG_MAX  = 24'hFFFFFF;
  localparam logic [REG_W-1:0]    QUARTER  = 24'h400000;  // knee at 131072 exactly

  typedef enum int {MIX_ANY, MIX_QUIET, MIX_KNEE, MIX_LOUD} mix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic signed [SAMPLE_W-1:0] left_sample = '0;
  logic signed [SAMPLE_W-1:0] right_sample = '0;
  logic end_of_buffer = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic signed [OUT_W-1:0] left_out;
  logic signed [OUT_W-1:0] right_out;
  logic [GAIN_W-1:0] applied_gain;
  logic end_of_buffer_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_data = '0;

  limiter_ledger ledger = new();
  frame_result_t seen;
  bit steady = 1'b0;
  int quiet_cycles = 0;
  int settings_used = 0;

  always #5 clk = ~clk;

  stereo_peak_limiter dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .left_sample(left_sample), .right_sample(right_sample), .end_of_buffer(end_of_buffer),
    .empty(empty), .pop(pop),
    .left_out(left_out), .right_out(right_out), .applied_gain(applied_gain),
    .end_of_buffer_out(end_of_buffer_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // transaction monitor; results first so a same-edge frame cannot mask a stray one
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) begin
        seen.left  = left_out;
        seen.right = right_out;
        seen.gain  = applied_gain;
        seen.eob   = end_of_buffer_out;
        ledger.check_frame(seen);
      end
      if (push && !full) ledger.note_frame(left_sample, right_sample, end_of_buffer);
      if (cfg_valid && cfg_ready) ledger.write_reg(slpk_cfg_idx_t'(cfg_index), cfg_data);
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
             STALL_LIMIT, ledger.pending());
    $display("stereo_peak_limiter: mismatch");
    $finish;
  end

  // result side stalls
  initial begin
    forever begin
      @(negedge clk);
      pop <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic send_frame(input logic signed [SAMPLE_W-1:0] l,
                            input logic signed [SAMPLE_W-1:0] r, input logic eob);
    @(negedge clk);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push          <= 1'b1;
    left_sample   <= l;
    right_sample  <= r;
    end_of_buffer <= eob;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    push <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  task automatic set_register(input slpk_cfg_idx_t idx, input logic [REG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_setting(input logic [REG_W-1:0] thr, input logic [REG_W-1:0] atk,
                               input logic [REG_W-1:0] rel);
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    set_register(CFG_THRESHOLD, thr);
    set_register(CFG_ATTACK, atk);
    set_register(CFG_RELEASE, rel);
    settings_used++;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(mix_t mix, int knee);
    int mag;
    int v;
    case (mix)
      MIX_ANY:   return SAMPLE_W'($urandom);
      MIX_QUIET: mag = int'($urandom_range(4095));
      MIX_KNEE:  mag = knee + int'($urandom_range(128)) - 64;
      default:   mag = int'($urandom_range(FULL_MAG, knee));
    endcase
    if (mag < 0) mag = 0;
    v = $urandom_range(1) ? -mag : mag;
    if (v > MAX_POS) v = MAX_POS;
    return SAMPLE_W'(v);
  endfunction

  // bursts of one character so the gain both falls and recovers
  task automatic random_phase(input int count);
    int burst_left;
    int knee;
    mix_t mix;
    logic signed [SAMPLE_W-1:0] l;
    logic signed [SAMPLE_W-1:0] r;
    burst_left = 0;
    mix = MIX_ANY;
    knee = int'(ledger.thr_level >> SAMPLE_INT_BITS);
    for (int i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        mix = mix_t'($urandom_range(3));
        burst_left = $urandom_range(40, 1);
      end
      burst_left--;
      if (i == count / 2) hold_until_drained();
      l = pick_sample(mix, knee);
      r = pick_sample(mix, knee);
      send_frame(l, r, $urandom_range(3) == 0);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // register defaults after reset; knee sits between 467272 and 467273
    send_frame('0, '0, 1'b0);
    send_frame(POS_FULL, POS_FULL, 1'b1);
    send_frame(NEG_FULL, NEG_FULL, 1'b0);
    send_frame(POS_FULL, NEG_FULL, 1'b0);
    send_frame(NEG_FULL, POS_FULL, 1'b1);
    send_frame(24'sd1, -24'sd1, 1'b0);
    send_frame(24'sd467272, -24'sd467272, 1'b0);
    send_frame(24'sd467273, '0, 1'b1);
    send_frame('0, -24'sd467273, 1'b0);
    send_frame(24'sd524288, -24'sd524288, 1'b0);
    repeat (3) send_frame(24'sd1000, -24'sd1000, 1'b0);

    // peak exactly at threshold must not limit
    apply_setting(QUARTER, REG_MAX, REG_MAX);
    send_frame(24'sd131072, -24'sd131072, 1'b0);
    send_frame(24'sd131073, '0, 1'b1);
    send_frame('0, -24'sd131073, 1'b0);
    send_frame(24'sd64, 24'sd64, 1'b0);

    // zero threshold: any nonzero peak targets zero gain
    apply_setting('0, REG_MAX, '0);
    send_frame('0, '0, 1'b1);
    send_frame(24'sd1, '0, 1'b0);
    send_frame('0, -24'sd1, 1'b0);
    send_frame(POS_FULL, NEG_FULL, 1'b1);

    apply_setting(THRESHOLD_RESET, ATTACK_RESET, RELEASE_RESET);
    random_phase(PHASE_FRAMES);
    apply_setting(REG_MAX, REG_MAX, REG_MAX);
    random_phase(PHASE_FRAMES);
    apply_setting('0, '0, REG_MAX);
    steady = 1'b1;
    random_phase(PHASE_FRAMES);
    steady = 1'b0;
    apply_setting(QUARTER, REG_MAX, '0);
    random_phase(PHASE_FRAMES);
    apply_setting(REG_MAX, '0, '0);
    random_phase(PHASE_FRAMES);
    apply_setting(REG_W'($urandom), REG_W'($urandom), REG_W'($urandom));
    random_phase(PHASE_FRAMES);
    apply_setting(REG_W'($urandom), REG_W'($urandom_range(65535)), REG_W'($urandom_range(4095)));
    random_phase(PHASE_FRAMES);

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("stereo_peak_limiter_tb: %0d frames sent, %0d results checked, %0d register settings",
             ledger.frames_noted, ledger.results_checked, settings_used);
    $display("stereo_peak_limiter_tb: %0d frames pulled the gain down, lowest gain %0d",
             ledger.reductions, ledger.lowest_gain);
    if (ledger.pending() != 0)
      $display("ERROR: %0d expected results never arrived", ledger.pending());
    if (ledger.mismatches == 0 && ledger.pending() == 0)
      $display("stereo_peak_limiter: match");
    else
      $display("stereo_peak_limiter: mismatch");
    $finish;
  end

endmodule

// File: files.f
sv/slpk_pkg.sv
sv/slpk_front.sv
sv/slpk_queue.sv
sv/slpk_div.sv
sv/slpk_back.sv
sv/stereo_peak_limiter.sv
sim/limiter_check_pkg.sv
sim/stereo_peak_limiter_tb.sv
